// ===== hw/rtl/hjte_pkg.sv =====
// Package for the HTML / JS text escaper: payload structs, sequence kinds,
// queue job type and the escape byte table. No dependencies.
package hjte_pkg;

	localparam int unsigned CountW  = 12;
	localparam int unsigned BudgetW = 13;
	localparam int unsigned LenW    = 3;
	localparam logic [BudgetW-1:0] BudgetCap   = 13'd4096;
	localparam logic [BudgetW-1:0] BudgetReset = 13'd1536;

	typedef enum logic {
		MODE_HTML = 1'b0,
		MODE_JS   = 1'b1
	} escape_mode_t;

	typedef enum logic {
		REG_ESCAPE_MODE   = 1'b0,
		REG_OUTPUT_BUDGET = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} src_item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              run_last;
		logic              string_done;
		logic [CountW-1:0] out_length;
	} dst_item_t;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_AMP,
		KIND_LT,
		KIND_GT,
		KIND_QUOT,
		KIND_APOS,
		KIND_JS
	} seq_kind_t;

	// One queued run of output bytes.
	typedef struct packed {
		logic              eot;
		seq_kind_t         kind;
		logic [7:0]        ch;
		logic [LenW-1:0]   len;
		logic [CountW-1:0] base;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_port_t;

	function automatic logic [LenW-1:0] seq_len(input seq_kind_t kind);
		unique case (kind)
			KIND_PLAIN: seq_len = 3'd1;
			KIND_JS:    seq_len = 3'd2;
			KIND_LT,
			KIND_GT:    seq_len = 3'd4;
			KIND_AMP,
			KIND_APOS:  seq_len = 3'd5;
			KIND_QUOT:  seq_len = 3'd6;
			default:    seq_len = 3'd1;
		endcase
	endfunction

	function automatic seq_kind_t classify(input escape_mode_t mode, input logic [7:0] ch);
		classify = KIND_PLAIN;
		if (mode == MODE_HTML) begin
			case (ch)
				8'h26:   classify = KIND_AMP;
				8'h3C:   classify = KIND_LT;
				8'h3E:   classify = KIND_GT;
				8'h22:   classify = KIND_QUOT;
				8'h27:   classify = KIND_APOS;
				default: classify = KIND_PLAIN;
			endcase
		end else begin
			case (ch)
				8'h5C, 8'h22, 8'h27: classify = KIND_JS;
				default:             classify = KIND_PLAIN;
			endcase
		end
	endfunction

	// Byte k of the escaped sequence; entities are left-aligned in 48 bits.
	function automatic logic [7:0] seq_byte(input seq_kind_t kind, input logic [7:0] ch,
		input logic [LenW-1:0] k);
		logic [47:0] ent;
		ent = 48'h0;
		seq_byte = ch;
		unique case (kind)
			KIND_AMP:  ent = {"&amp;", 8'h00};
			KIND_LT:   ent = {"&lt;", 16'h0000};
			KIND_GT:   ent = {"&gt;", 16'h0000};
			KIND_QUOT: ent = "&quot;";
			KIND_APOS: ent = {"&#39;", 8'h00};
			default:   ent = 48'h0;
		endcase
		unique case (kind)
			KIND_PLAIN: seq_byte = ch;
			KIND_JS:    seq_byte = (k == 3'd0) ? 8'h5C : ch;
			default:    seq_byte = ent[6'd47 - {k, 3'b000} -: 8];
		endcase
	endfunction

endpackage

// ===== hw/rtl/hjte_front.sv =====
// Front part: accepts items, classifies them and checks the budget.
// Depends on hjte_pkg.
module hjte_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       src_valid,
	output logic                       src_stall,
	input  hjte_pkg::src_item_t        src_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  hjte_pkg::cfg_reg_t         cfg_index,
	input  logic [hjte_pkg::BudgetW-1:0] cfg_data,
	input  logic                       q_full,
	output hjte_pkg::job_port_t        push
);
	import hjte_pkg::*;

	escape_mode_t       mode_q;
	logic [BudgetW-1:0] budget_q;
	logic [CountW-1:0]  count_q;
	logic               stopped_q;

	seq_kind_t          kind;
	logic [LenW-1:0]    len;
	logic [BudgetW-1:0] cap;
	logic [BudgetW-1:0] sum;
	logic               fits;
	logic               accept;

	assign cfg_ready = 1'b1;
	assign src_stall = q_full;
	assign accept    = src_valid && !q_full;

	always_comb begin
		kind = classify(mode_q, src_data.text_byte);
		len  = seq_len(kind);
		cap  = (budget_q > BudgetCap) ? BudgetCap : budget_q;
		sum  = {1'b0, count_q} + {{(BudgetW-LenW){1'b0}}, len};
		fits = sum < cap;

		push.valid    = accept && (src_data.end_of_text || (!stopped_q && fits));
		push.job.eot  = src_data.end_of_text;
		push.job.kind = src_data.end_of_text ? KIND_PLAIN : kind;
		push.job.ch   = src_data.end_of_text ? 8'h00 : src_data.text_byte;
		push.job.len  = src_data.end_of_text ? 3'd1 : len;
		push.job.base = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_HTML;
			budget_q  <= BudgetReset;
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ESCAPE_MODE:   mode_q   <= escape_mode_t'(cfg_data[0]);
					REG_OUTPUT_BUDGET: budget_q <= cfg_data;
					default:           ;
				endcase
			end
			if (accept) begin
				if (src_data.end_of_text) begin
					count_q   <= '0;
					stopped_q <= 1'b0;
				end else if (!stopped_q) begin
					if (fits) begin
						count_q <= sum[CountW-1:0];
					end else begin
						stopped_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/hjte_queue.sv =====
// Two-entry job queue between front and back parts.
// Depends on hjte_pkg.
module hjte_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  hjte_pkg::job_port_t push,
	output logic                full,
	input  logic                pop,
	output hjte_pkg::job_port_t head
);
	import hjte_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head.valid = (cnt_q != 2'd0);
	assign head.job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push.valid) wr_q <= ~wr_q;
			if (pop)        rd_q <= ~rd_q;
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/hjte_back.sv =====
// Back part: expands queued jobs into result beats, one byte per cycle while dst is not stalled.
// Depends on hjte_pkg.
module hjte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hjte_pkg::job_port_t head,
	output logic                pop,
	output logic                dst_valid,
	input  logic                dst_stall,
	output hjte_pkg::dst_item_t dst_data
);
	import hjte_pkg::*;

	logic [LenW-1:0] k_q;
	logic            dst_valid_q;
	dst_item_t       dst_q;
	logic            advance;
	logic            last;
	dst_item_t       beat;

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_q;
	assign advance   = head.valid && (!dst_valid_q || !dst_stall);
	assign last      = (k_q == head.job.len - 3'd1);
	assign pop       = advance && last;

	always_comb begin
		beat.out_byte    = head.job.eot ? 8'h00 : seq_byte(head.job.kind, head.job.ch, k_q);
		beat.run_last    = last;
		beat.string_done = head.job.eot;
		beat.out_length  = head.job.eot ? head.job.base
			: head.job.base + {{(CountW-LenW){1'b0}}, k_q} + 12'd1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dst_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			dst_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				k_q         <= last ? '0 : k_q + 3'd1;
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/html_js_text_escaper.sv =====
// An item's first result beat reaches dst through the job queue and the result register.
// Throughput: one result beat per cycle while dst is not stalled; a character yields one
// beat per escaped byte (1 plain, 2 JS, 4 to 6 for an entity), via the back part's counter.
// The two-entry job queue lets the source run ahead while a long entity drains.
// Reset (arst_n low, asynchronous): mode HTML, budget 1536, count and stop flag cleared,
// queue emptied, no result beat pending.
module html_js_text_escaper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         src_valid,
	output logic                         src_stall,
	input  hjte_pkg::src_item_t          src_data,
	output logic                         dst_valid,
	input  logic                         dst_stall,
	output hjte_pkg::dst_item_t          dst_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  hjte_pkg::cfg_reg_t           cfg_index,
	input  logic [hjte_pkg::BudgetW-1:0] cfg_data
);
	import hjte_pkg::*;

	// Jobs flow front -> queue -> back; the queue head is held until its last beat.
	job_port_t push;
	job_port_t head;
	logic      q_full;
	logic      pop;

	// Classify each beat, keep the running count and drop output once a text's count would reach the budget.
	hjte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push)
	);

	// Hold up to two pending runs so a stalled sink blocks classification only once both are full.
	hjte_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// Advance through each run's bytes into the registered result beat.
	hjte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule
